// ----- rtl/dpmn_pkg.sv -----
// ============================================================================
// dpmn_pkg
// Shared widths, constants and register indexes of the DisplayPort M/N
// ratio calculator.
// ============================================================================
package dpmn_pkg;

  // Width of each reduced M and N field
  localparam int unsigned MN_FIELD_BITS = 24;

  // Field widths of the ports
  localparam int unsigned BPP_W   = 7;
  localparam int unsigned CLK_W   = 20;
  localparam int unsigned LANES_W = 3;
  localparam int unsigned CFG_W   = 20;

  // Datapath widths: bpp*pclk, link*lanes*8, and the left-aligned dividend
  localparam int unsigned NUM_W   = BPP_W + CLK_W;
  localparam int unsigned DEN_W   = CLK_W + LANES_W + 3;
  localparam int unsigned DATA_SH = 27;
  localparam int unsigned LINK_SH = 19;
  localparam int unsigned DVD_W   = NUM_W + DATA_SH;
  localparam int unsigned QUO_W   = 32;

  // Division steps for each ratio, one quotient bit per step
  localparam int unsigned DATA_STEPS = NUM_W + DATA_SH;
  localparam int unsigned LINK_STEPS = CLK_W + LINK_SH;
  localparam int unsigned CNT_W      = $clog2(DATA_STEPS);

  // Fixed denominators before reduction
  localparam logic [QUO_W-1:0] DATA_CONST_N = 32'h0800_0000;
  localparam logic [QUO_W-1:0] LINK_CONST_N = 32'h0008_0000;

  // Largest value that fits an M/N field
  localparam logic [QUO_W:0] MN_LIMIT = (33'd1 << MN_FIELD_BITS) - 33'd1;

  // Register reset values
  localparam logic [BPP_W-1:0] BPP_RESET      = 7'd24;
  localparam logic [CLK_W-1:0] LINK_CLK_RESET = 20'd270000;

  // Configuration register indexes
  localparam logic CFG_BPP      = 1'b0;
  localparam logic CFG_LINK_CLK = 1'b1;

endpackage

// ----- rtl/dp_link_m_n_calculator_top.sv -----
// ============================================================================
// dp_link_m_n_calculator_top
// DisplayPort data and link M/N ratio calculator on one shared divider.
// ============================================================================
// Usage:
//   Program bits_per_pixel (index 0) and link_clock_khz (index 1) through the
//   write port while the block is idle. Then present a pixel clock in kHz and
//   a lane count on the input channel; one beat is taken when in_valid_i and
//   in_ready_o are both high. The result beat carries data M/N and link M/N,
//   each pair shifted right together until both fit MN_FIELD_BITS bits.
// Operation:
//   A single restoring divider, one quotient bit per cycle, computes both
//   ratios in turn: 54 steps for the data ratio and 39 for the link ratio.
//   Each is followed by right shifts of the pair and a final fit check.
//   With 24-bit fields the data pair takes 4 to 8 shifts and the link pair 0
//   to 8. One item is in work at a time: in_ready_o is high only when idle,
//   so a new item is taken only after the result beat has been taken.
// Reset and stall:
//   Reset restores bits_per_pixel = 24 and link_clock_khz = 270000 and
//   returns the block to idle. A result holds on the output until
//   out_ready_i takes it; the next item is accepted the cycle after.
// ============================================================================
module dp_link_m_n_calculator_top
  import dpmn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CLK_W-1:0]         pixel_clock_khz_i,
  input  logic [LANES_W-1:0]       lane_count_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [MN_FIELD_BITS-1:0] data_m_o,
  output logic [MN_FIELD_BITS-1:0] data_n_o,
  output logic [MN_FIELD_BITS-1:0] link_m_o,
  output logic [MN_FIELD_BITS-1:0] link_n_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RED,
    ST_OUT
  } state_e;

  state_e                   state_q;
  logic                     link_phase_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [DVD_W-1:0]         dvd_q;
  logic [DEN_W-1:0]         den_q;
  logic [DEN_W-1:0]         rem_q;
  logic [QUO_W-1:0]         quo_q;
  logic [QUO_W-1:0]         m_q;
  logic [QUO_W-1:0]         n_q;
  logic [CLK_W-1:0]         pclk_q;
  logic [BPP_W-1:0]         bpp_q;
  logic [CLK_W-1:0]         link_clk_q;
  logic [MN_FIELD_BITS-1:0] data_m_q;
  logic [MN_FIELD_BITS-1:0] data_n_q;
  logic [MN_FIELD_BITS-1:0] link_m_q;
  logic [MN_FIELD_BITS-1:0] link_n_q;

  logic [NUM_W-1:0] num_data;
  logic [DEN_W-1:0] den_data;
  logic [DEN_W:0]   rem_shift;
  logic             rem_ge;
  logic [DEN_W-1:0] rem_d;
  logic [QUO_W-1:0] quo_d;
  logic             over_limit;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q      <= BPP_RESET;
      link_clk_q <= LINK_CLK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BPP:      bpp_q      <= cfg_data_i[BPP_W-1:0];
        CFG_LINK_CLK: link_clk_q <= cfg_data_i[CLK_W-1:0];
        default:      ;
      endcase
    end
  end

  // Form the data ratio numerator and divisor at accept
  assign num_data = NUM_W'(bpp_q) * NUM_W'(pixel_clock_khz_i);
  assign den_data = {(CLK_W + LANES_W)'(link_clk_q) * (CLK_W + LANES_W)'(lane_count_i), 3'b000};

  // One restoring step; a zero divisor yields all-one quotient bits
  assign rem_shift = {rem_q, dvd_q[DVD_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, den_q};
  assign rem_d     = rem_ge ? DEN_W'(rem_shift - {1'b0, den_q}) : rem_shift[DEN_W-1:0];
  assign quo_d     = {quo_q[QUO_W-2:0], rem_ge};

  // Either value of the pair still too wide for the field
  assign over_limit = ({1'b0, m_q} > MN_LIMIT) || ({1'b0, n_q} > MN_LIMIT);

  // Sequence: divide, reduce, repeat for the link ratio, then present
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      link_phase_q <= 1'b0;
      cnt_q        <= '0;
      dvd_q        <= '0;
      den_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      m_q          <= '0;
      n_q          <= '0;
      pclk_q       <= '0;
      data_m_q     <= '0;
      data_n_q     <= '0;
      link_m_q     <= '0;
      link_n_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            pclk_q       <= pixel_clock_khz_i;
            dvd_q        <= {num_data, DATA_SH'(0)};
            den_q        <= den_data;
            rem_q        <= '0;
            quo_q        <= '0;
            cnt_q        <= CNT_W'(DATA_STEPS - 1);
            link_phase_q <= 1'b0;
            state_q      <= ST_DIV;
          end
        end
        ST_DIV: begin
          dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            m_q     <= quo_d;
            n_q     <= link_phase_q ? LINK_CONST_N : DATA_CONST_N;
            state_q <= ST_RED;
          end
        end
        ST_RED: begin
          if (over_limit) begin
            m_q <= {1'b0, m_q[QUO_W-1:1]};
            n_q <= {1'b0, n_q[QUO_W-1:1]};
          end else if (!link_phase_q) begin
            // Store the data pair and start the link division
            data_m_q     <= m_q[MN_FIELD_BITS-1:0];
            data_n_q     <= n_q[MN_FIELD_BITS-1:0];
            dvd_q        <= {pclk_q, (DVD_W - CLK_W)'(0)};
            den_q        <= DEN_W'(link_clk_q);
            rem_q        <= '0;
            quo_q        <= '0;
            cnt_q        <= CNT_W'(LINK_STEPS - 1);
            link_phase_q <= 1'b1;
            state_q      <= ST_DIV;
          end else begin
            link_m_q <= m_q[MN_FIELD_BITS-1:0];
            link_n_q <= n_q[MN_FIELD_BITS-1:0];
            state_q  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign data_m_o    = data_m_q;
  assign data_n_o    = data_n_q;
  assign link_m_o    = link_m_q;
  assign link_n_o    = link_n_q;

endmodule

// ----- rtl/dpmn_checker.sv -----
// ============================================================================
// dpmn_checker
// Port-level checks of the M/N ratio calculator, bound to the top level.
// ============================================================================
module dpmn_checker
  import dpmn_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_we_i,
  input logic                     cfg_idx_i,
  input logic [CFG_W-1:0]         cfg_data_i,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic [CLK_W-1:0]         pixel_clock_khz_i,
  input logic [LANES_W-1:0]       lane_count_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [MN_FIELD_BITS-1:0] data_m_o,
  input logic [MN_FIELD_BITS-1:0] data_n_o,
  input logic [MN_FIELD_BITS-1:0] link_m_o,
  input logic [MN_FIELD_BITS-1:0] link_n_o
);

  // Never take a new beat while a result is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result valid");

  // Drop ready once an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("ready or valid right after accept");

  // Return to idle once the result beat is taken
  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o && !out_valid_o)
    else $error("not idle after result beat");

  // Hold the result while stalled
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_m_o) &&
      $stable(data_n_o) && $stable(link_m_o) && $stable(link_n_o))
    else $error("result changed while stalled");

  // Reduced denominators never shift down to zero
  a_n_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (data_n_o != '0) && (link_n_o != '0))
    else $error("zero denominator on output");

endmodule

bind dp_link_m_n_calculator_top dpmn_checker u_dpmn_checker (.*);
